// ===== rtl/kpc_pkg.sv =====
package kpc_pkg;

  localparam int GridSideDef = 6;
  localparam int SymW        = 8;
  localparam int DigitW      = 3;
  localparam int FillLen     = 36;
  localparam int CandW       = 6;
  localparam int LetterCount = 26;
  localparam int OutDepth    = 4;
  localparam int OutPtrW     = 2;
  localparam int OutCntW     = 3;

  localparam logic [SymW-1:0] SpaceSym  = 8'h20;
  localparam logic [SymW-1:0] DigitZero = 8'h30;
  localparam logic [SymW-1:0] LetterA   = 8'h41;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_KEY_END = 2'd1,
    OP_TEXT    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_SECOND
  } state_t;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
    logic            error;
  } result_t;

  typedef struct packed {
    logic              append;
    logic              clear;
    logic [SymW-1:0]   query;
    logic [DigitW-1:0] sel_row;
    logic [DigitW-1:0] sel_col;
  } chain_cmd_t;

  typedef struct packed {
    logic              found;
    logic [DigitW-1:0] hit_row;
    logic [DigitW-1:0] hit_col;
    logic              full;
    logic [SymW-1:0]   rd_sym;
    logic              rd_filled;
  } chain_stat_t;

  // Letters A to Z first, then the digits 0 to 9.
  function automatic logic [SymW-1:0] fill_symbol(input logic [CandW-1:0] idx);
    logic [SymW-1:0] wide;
    wide = {{(SymW-CandW){1'b0}}, idx};
    if (wide < SymW'(LetterCount)) begin
      fill_symbol = LetterA + wide;
    end else begin
      fill_symbol = DigitZero + wide - SymW'(LetterCount);
    end
  endfunction

endpackage

// ===== rtl/kpc_if.sv =====
interface kpc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] symbol;

  modport source (output valid, output operation, output symbol, input ready);
  modport sink (input valid, input operation, input symbol, output ready);
endinterface

interface kpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_symbol;
  logic       last;
  logic       error;

  modport source (output valid, output out_symbol, output last, output error, input ready);
  modport sink (input valid, input out_symbol, input last, input error, output ready);
endinterface

// ===== rtl/keyed_polybius_cipher.sv =====
// Keyed 6x6 Polybius square cipher.
//
// Input words arrive on in_chan (operation, symbol), results leave on out_chan
// (out_symbol, last, error); both use a valid/ready handshake and a word moves
// at a rising edge with valid and ready high. The one register, encrypt_mode, is
// to be written via cfg_we/cfg_wdata only while the block is idle, unenforced.
//
// Key symbol, text symbol and ignored words leave the block idle after they are
// taken. A text word in encrypt mode that names a grid symbol yields two results
// and holds off the next word while its second result is written in ST_SECOND.
// Key end walks the 36 fill candidates, one a cycle, in ST_FILL, and no word is
// taken until the walk is done. The first result of a word is written into the
// output queue as the word is taken.
//
// The grid lives in a row of cells; each cell learns from its left neighbour
// whether it is the next free slot, and every cell compares the broadcast
// symbol at once. Results go through a four-word output queue, so a stalled
// receiver does not stop new words while two slots remain free.
// Synchronous reset empties the grid, clears the queue and sets encrypt mode.
module keyed_polybius_cipher #(
  parameter int GRID_SIDE = kpc_pkg::GridSideDef
) (
  input  logic             clk,
  input  logic             rst_n,
  kpc_in_if.sink           in_chan,
  kpc_out_if.source        out_chan,
  input  logic             cfg_we,
  input  logic             cfg_wdata
);

  localparam logic [kpc_pkg::DigitW-1:0] BadRow = kpc_pkg::DigitW'(GRID_SIDE);
  localparam logic [kpc_pkg::CandW-1:0]  CandLast = kpc_pkg::CandW'(kpc_pkg::FillLen - 1);

  kpc_pkg::state_t      state_r, state_nxt;
  kpc_pkg::chain_cmd_t  cmd;
  kpc_pkg::chain_stat_t stat;
  kpc_pkg::op_t         op;

  logic                        encrypt_mode_r;
  logic                        key_closed_r, key_closed_nxt;
  logic                        row_pending_r, row_pending_nxt;
  logic [kpc_pkg::DigitW-1:0]  pending_row_r, pending_row_nxt;
  logic [kpc_pkg::DigitW-1:0]  col_r, col_nxt;
  logic [kpc_pkg::CandW-1:0]   cand_r, cand_nxt;

  logic                        in_acc;
  logic                        in_space;
  logic                        in_dig_ok;
  logic [kpc_pkg::DigitW-1:0]  in_digit;

  // Output queue.
  kpc_pkg::result_t            fifo_r [kpc_pkg::OutDepth];
  logic [kpc_pkg::OutPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [kpc_pkg::OutCntW-1:0] cnt_r;
  logic                        push, pop;
  kpc_pkg::result_t            push_word;

  assign op       = kpc_pkg::op_t'(in_chan.operation);
  assign in_acc   = in_chan.valid & in_chan.ready;
  assign in_space = (in_chan.symbol == kpc_pkg::SpaceSym);
  assign in_dig_ok = (in_chan.symbol >= kpc_pkg::DigitZero) &&
                     (in_chan.symbol < kpc_pkg::DigitZero + kpc_pkg::SymW'(GRID_SIDE));
  assign in_digit = kpc_pkg::DigitW'(in_chan.symbol - kpc_pkg::DigitZero);

  // Words are taken only when two queue slots are free, which covers the two
  // results that one word can leave behind.
  assign in_chan.ready = (state_r == kpc_pkg::ST_IDLE) &&
                         (cnt_r <= kpc_pkg::OutCntW'(kpc_pkg::OutDepth - 2));

  kpc_chain #(
    .GRID_SIDE (GRID_SIDE)
  ) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (op == kpc_pkg::OP_KEY_END) begin
            state_nxt = kpc_pkg::ST_FILL;
          end else if (op == kpc_pkg::OP_TEXT && encrypt_mode_r && !in_space && stat.found) begin
            state_nxt = kpc_pkg::ST_SECOND;
          end
        end
      end
      kpc_pkg::ST_FILL: begin
        if (cand_r == CandLast) begin
          state_nxt = kpc_pkg::ST_IDLE;
        end
      end
      kpc_pkg::ST_SECOND: begin
        state_nxt = kpc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kpc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    cmd.append      = 1'b0;
    cmd.clear       = 1'b0;
    cmd.query       = in_chan.symbol;
    cmd.sel_row     = pending_row_r;
    cmd.sel_col     = in_digit;
    push            = 1'b0;
    push_word       = '{sym: kpc_pkg::SpaceSym, last: 1'b1, error: 1'b0};
    key_closed_nxt  = key_closed_r;
    row_pending_nxt = row_pending_r;
    pending_row_nxt = pending_row_r;
    col_nxt         = col_r;
    cand_nxt        = cand_r;
    case (state_r)
      kpc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (op)
            kpc_pkg::OP_KEY: begin
              row_pending_nxt = 1'b0;
              pending_row_nxt = '0;
              cmd.append      = 1'b1;
              // A key after a closed key starts a fresh grid.
              cmd.clear       = key_closed_r;
              key_closed_nxt  = 1'b0;
            end
            kpc_pkg::OP_KEY_END: begin
              row_pending_nxt = 1'b0;
              pending_row_nxt = '0;
              cand_nxt        = '0;
            end
            kpc_pkg::OP_TEXT: begin
              if (encrypt_mode_r) begin
                row_pending_nxt = 1'b0;
                pending_row_nxt = '0;
                if (in_space) begin
                  push = 1'b1;
                end else if (stat.found) begin
                  push      = 1'b1;
                  push_word = '{sym: kpc_pkg::DigitZero + kpc_pkg::SymW'(stat.hit_row),
                                last: 1'b0, error: 1'b0};
                  col_nxt   = stat.hit_col;
                end
              end else if (!row_pending_r) begin
                if (in_space) begin
                  push = 1'b1;
                end else begin
                  row_pending_nxt = 1'b1;
                  pending_row_nxt = in_dig_ok ? in_digit : BadRow;
                end
              end else begin
                row_pending_nxt = 1'b0;
                pending_row_nxt = '0;
                push            = 1'b1;
                if (pending_row_r == BadRow || !in_dig_ok || !stat.rd_filled) begin
                  push_word = '{sym: '0, last: 1'b1, error: 1'b1};
                end else begin
                  push_word = '{sym: stat.rd_sym, last: 1'b1, error: 1'b0};
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      kpc_pkg::ST_FILL: begin
        cmd.query  = kpc_pkg::fill_symbol(cand_r);
        cmd.append = 1'b1;
        cand_nxt   = cand_r + 1'b1;
        if (cand_r == CandLast) begin
          key_closed_nxt = 1'b1;
        end
      end
      kpc_pkg::ST_SECOND: begin
        push      = 1'b1;
        push_word = '{sym: kpc_pkg::DigitZero + kpc_pkg::SymW'(col_r), last: 1'b1, error: 1'b0};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= kpc_pkg::ST_IDLE;
      encrypt_mode_r <= 1'b1;
      key_closed_r   <= 1'b0;
      row_pending_r  <= 1'b0;
      pending_row_r  <= '0;
      cand_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      key_closed_r  <= key_closed_nxt;
      row_pending_r <= row_pending_nxt;
      pending_row_r <= pending_row_nxt;
      cand_r        <= cand_nxt;
      if (cfg_we) begin
        encrypt_mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end

  // Output queue: one word written and one read per cycle at most.
  assign pop            = out_chan.valid & out_chan.ready;
  assign out_chan.valid = (cnt_r != '0);
  assign out_chan.out_symbol = fifo_r[rd_ptr_r].sym;
  assign out_chan.last  = fifo_r[rd_ptr_r].last;
  assign out_chan.error = fifo_r[rd_ptr_r].error;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + kpc_pkg::OutCntW'(push) - kpc_pkg::OutCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_word;
    end
  end

  // The queue never holds more words than it has slots.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= kpc_pkg::OutCntW'(kpc_pkg::OutDepth))
    else $error("output queue overflow");

  // The second digit of a pair only ever follows a word taken the cycle before.
  a_second_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == kpc_pkg::ST_SECOND |-> $past(in_acc))
    else $error("second digit without a preceding word");

  // A stored row digit exists only while a row is pending.
  a_row_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !row_pending_r |-> pending_row_r == '0)
    else $error("stale decrypt row digit");

  // The key closes only at the end of the fill walk, which leaves the grid full.
  a_close_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_closed_r) |-> stat.full && $past(state_r == kpc_pkg::ST_FILL))
    else $error("key closed without a full grid");

endmodule

// ===== rtl/kpc_cell.sv =====
module kpc_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kpc_pkg::chain_cmd_t        cmd,
  input  logic                       wr_go,
  input  logic                       prev_in,
  input  logic [kpc_pkg::DigitW-1:0] row_id,
  input  logic [kpc_pkg::DigitW-1:0] col_id,
  output logic                       filled,
  output logic                       match,
  output logic                       sel_hit,
  output logic [kpc_pkg::SymW-1:0]   rd_sym
);

  logic                     filled_r;
  logic                     filled_nxt;
  logic [kpc_pkg::SymW-1:0] sym_r;
  logic                     keep;
  logic                     take;

  // A cell takes the symbol on a write when its left neighbour is occupied and it is not.
  assign keep       = filled_r & ~cmd.clear;
  assign take       = wr_go & prev_in & ~keep;
  assign filled_nxt = keep | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= 1'b0;
    end else begin
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sym_r <= cmd.query;
    end
  end

  assign filled  = filled_r;
  assign match   = filled_r & (sym_r == cmd.query);
  assign sel_hit = filled_r & (row_id == cmd.sel_row) & (col_id == cmd.sel_col);
  assign rd_sym  = sel_hit ? sym_r : '0;

endmodule

// ===== rtl/kpc_chain.sv =====
module kpc_chain #(
  parameter int GRID_SIDE = kpc_pkg::GridSideDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kpc_pkg::chain_cmd_t  cmd,
  output kpc_pkg::chain_stat_t stat
);

  localparam int Cells = GRID_SIDE * GRID_SIDE;

  logic [Cells-1:0]          filled;
  logic [Cells-1:0]          match;
  logic [Cells-1:0]          sel_hit;
  logic [Cells-1:0]          prev;
  logic [kpc_pkg::SymW-1:0]  rd_sym   [Cells];
  logic [kpc_pkg::DigitW-1:0] row_ids [Cells];
  logic [kpc_pkg::DigitW-1:0] col_ids [Cells];
  logic                      dup;
  logic                      wr_go;

  assign dup   = |match;
  assign wr_go = cmd.append & (cmd.clear | (~dup & ~filled[Cells-1]));

  for (genvar i = 0; i < Cells; i++) begin : g_cell
    localparam int RowC = i / GRID_SIDE;
    localparam int ColC = i % GRID_SIDE;

    assign row_ids[i] = kpc_pkg::DigitW'(RowC);
    assign col_ids[i] = kpc_pkg::DigitW'(ColC);

    if (i == 0) begin : g_head
      assign prev[i] = 1'b1;
    end else begin : g_body
      assign prev[i] = filled[i-1] & ~cmd.clear;
    end

    kpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .wr_go   (wr_go),
      .prev_in (prev[i]),
      .row_id  (row_ids[i]),
      .col_id  (col_ids[i]),
      .filled  (filled[i]),
      .match   (match[i]),
      .sel_hit (sel_hit[i]),
      .rd_sym  (rd_sym[i])
    );
  end

  // Symbols in the grid are unique, so at most one cell matches and a plain
  // OR of the matching coordinates gives its position.
  always_comb begin
    stat.found     = dup;
    stat.full      = filled[Cells-1];
    stat.rd_filled = |sel_hit;
    stat.hit_row   = '0;
    stat.hit_col   = '0;
    stat.rd_sym    = '0;
    for (int k = 0; k < Cells; k++) begin
      stat.hit_row = stat.hit_row | (match[k] ? row_ids[k] : '0);
      stat.hit_col = stat.hit_col | (match[k] ? col_ids[k] : '0);
      stat.rd_sym  = stat.rd_sym | rd_sym[k];
    end
  end

endmodule
